// File: design/first_fit_heap_allocator_macros.svh
// assertion macros for the first-fit heap allocator
// used by the top level only, needs i_clk and i_rst_n in scope
`ifndef FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_MACROS_SVH

// implication checked at every clock edge outside reset
`define FFHA_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication checked outside reset
`define FFHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ffha_pkg.sv
// shared types and constants of the first-fit heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;

    localparam int unsigned HEAP_BASE    = 65536;
    localparam int unsigned HEADER_BYTES = 16;
    localparam int unsigned MAX_PAGES    = 4;
    localparam int unsigned ADDR_W       = 18;
    localparam int unsigned LEN_W        = 18;
    localparam int unsigned SIZE_W       = 32;
    localparam int unsigned PAGE_W       = 3;
    localparam int unsigned CHUNK_DEPTH  = (MAX_PAGES * 65536 - HEAP_BASE) / 8;
    localparam int unsigned IDX_W        = $clog2(CHUNK_DEPTH);

    typedef logic [1:0] t_cmd;
    localparam t_cmd CMD_ALLOC   = 2'd0;
    localparam t_cmd CMD_RELEASE = 2'd1;
    localparam t_cmd CMD_RESIZE  = 2'd2;
    localparam t_cmd CMD_NONE    = 2'd3;

    // one chunk header as held in memory, indexed by header address
    typedef struct packed {
        logic             used;
        logic [LEN_W-1:0] len;
    } t_entry;

    typedef enum logic [2:0] {
        S_FMT, S_IDLE, S_RD, S_EVAL, S_WR1, S_WR2, S_DONE
    } t_state;

    typedef enum logic [1:0] {
        PH_ALLOC, PH_FIND, PH_NEXT
    } t_phase;

    // memory index of a header address
    function automatic logic [IDX_W-1:0] f_idx(input logic [ADDR_W-1:0] addr);
        logic [ADDR_W-1:0] off;
        off = addr - ADDR_W'(HEAP_BASE);
        return off[IDX_W+2:3];
    endfunction

endpackage
`default_nettype wire

// File: design/ffha_if.sv
// request and result channel interfaces of the heap allocator
// depends on ffha_pkg
`default_nettype none
interface ffha_req_if;
    import ffha_pkg::*;
    logic                valid;
    logic                ready;
    logic [1:0]          command;
    logic [SIZE_W-1:0]   request_bytes;
    logic [ADDR_W-1:0]   block_address;
    modport source (output valid, command, request_bytes, block_address, input ready);
    modport sink   (input valid, command, request_bytes, block_address, output ready);
endinterface

interface ffha_res_if;
    import ffha_pkg::*;
    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   result_address;
    logic [ADDR_W-1:0]   copy_source;
    logic [LEN_W-1:0]    copy_bytes;
    logic                out_of_memory;
    modport source (output valid, result_address, copy_source, copy_bytes, out_of_memory,
                    input ready);
    modport sink   (input valid, result_address, copy_source, copy_bytes, out_of_memory,
                    output ready);
endinterface
`default_nettype wire

// File: design/ffha_ram.sv
// generic simple dual-port ram with registered read
// no dependencies
`default_nettype none
module ffha_ram #(
    parameter int unsigned WIDTH = 19,
    parameter int unsigned DEPTH = 24576
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

// File: design/first_fit_heap_allocator.sv
// first-fit heap allocator: chunk walk over a header memory
// depends on ffha_pkg, ffha_if, ffha_ram and the macros header
//
//  channel | dir | handshake      | payload
//  i_req   | in  | valid / ready  | command, request_bytes, block_address
//  o_res   | out | valid / ready  | result_address, copy_source, copy_bytes, out_of_memory
//  i_cfg   | in  | write enable   | memory_pages
//
// each chunk visited passes a memory read state, then an evaluate state; a request walks
// the chunks, then does its header writes in S_WR1 and S_WR2 and finishes in S_DONE,
// and the next request is taken back in S_IDLE.
// a moving resize walks three times: to find the block, to allocate and to release it.
// reset and a configuration write pass through S_FMT, which writes the single free header unless the heap is empty.
// a finished result waits in an output register; the next request is taken meanwhile.
`default_nettype none
`include "first_fit_heap_allocator_macros.svh"
module first_fit_heap_allocator (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic [ffha_pkg::PAGE_W-1:0]   i_cfg_wdata,
    ffha_req_if.sink                           i_req,
    ffha_res_if.source                         o_res
);
    import ffha_pkg::*;

    localparam logic [18:0] HDR19 = 19'(HEADER_BYTES);

    t_state r_state, n_state;
    t_phase r_phase;
    logic [PAGE_W-1:0] r_pages;
    logic [SIZE_W-1:0] r_size;
    logic [ADDR_W-1:0] r_m, r_at, r_fnd_at, r_prv_at;
    logic [LEN_W-1:0]  r_cur_len, r_prv_len, r_keep;
    logic              r_prv_ok, r_prv_used, r_moving, r_rel;
    logic [ADDR_W-1:0] r_res, r_src;
    logic [LEN_W-1:0]  r_bytes;
    logic              r_oom;
    logic [ADDR_W-1:0] r_wa1, r_wa2;
    t_entry            r_wd1, r_wd2;
    logic              r_two, r_after;
    logic              r_o_valid;
    logic [ADDR_W-1:0] r_o_res, r_o_src;
    logic [LEN_W-1:0]  r_o_bytes;
    logic              r_o_oom;

    // heap bounds
    logic [PAGE_W-1:0] eff_pages;
    logic [18:0]       heap_end;
    logic              heap_empty;
    assign eff_pages  = (r_pages > PAGE_W'(MAX_PAGES)) ? PAGE_W'(MAX_PAGES) : r_pages;
    assign heap_end   = {eff_pages, 16'b0};
    assign heap_empty = heap_end < 19'(HEAP_BASE + HEADER_BYTES);

    // header memory
    logic             mem_we, mem_re;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;
    t_entry           mem_wdata, rd;
    logic [18:0]      fmt_len;
    assign fmt_len = heap_end - 19'(HEAP_BASE + HEADER_BYTES);

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = f_idx(r_wa1);
        mem_wdata = r_wd1;
        case (r_state)
            S_FMT: begin
                mem_we    = !heap_empty;
                mem_waddr = '0;
                mem_wdata = '{used: 1'b0, len: fmt_len[LEN_W-1:0]};
            end
            S_WR1: begin
                mem_we = 1'b1;
            end
            S_WR2: begin
                mem_we    = 1'b1;
                mem_waddr = f_idx(r_wa2);
                mem_wdata = r_wd2;
            end
            default: mem_we = 1'b0;
        endcase
    end
    assign mem_re    = (r_state == S_RD);
    assign mem_raddr = f_idx(r_at);

    ffha_ram #(
        .WIDTH ($bits(t_entry)),
        .DEPTH (CHUNK_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (rd)
    );

    // walk step on the header just read
    logic [18:0] nxt_at, at_data;
    logic        is_last, is_hit, is_past, cur_fit;
    assign nxt_at  = 19'(r_at) + HDR19 + 19'(rd.len);
    assign is_last = nxt_at >= heap_end;
    assign at_data = 19'(r_at) + HDR19;
    assign is_hit  = at_data == 19'(r_m);
    assign is_past = at_data > 19'(r_m);
    assign cur_fit = !rd.used && (SIZE_W'(rd.len) >= r_size);

    // found chunk and its next neighbour
    logic              nx_ok, nx_free;
    logic [LEN_W-1:0]  nl, fl;
    logic [ADDR_W-1:0] fa;
    always_comb begin
        if (r_phase == PH_NEXT) begin
            nx_ok = 1'b1;
            nx_free = !rd.used;
            nl = rd.len;
            fl = r_cur_len;
            fa = r_fnd_at;
        end else begin
            nx_ok = 1'b0;
            nx_free = 1'b0;
            nl = rd.len;
            fl = rd.len;
            fa = r_at;
        end
    end

    // merge, grow and split arithmetic
    logic [18:0]       merged, grow_len, rel_len;
    logic              grow_ok, do_split;
    logic [32:0]       rs;
    logic [LEN_W-1:0]  sp_len, keep, rel_len18;
    logic [ADDR_W-1:0] sp_at;
    logic [18:0]       keep_r;
    assign merged   = 19'(fl) + ((nx_ok && nx_free) ? (19'(nl) + HDR19) : 19'd0);
    assign grow_len = 19'(fl) + 19'(nl) + HDR19;
    assign grow_ok  = nx_ok && nx_free && (SIZE_W'(grow_len) >= r_size);
    assign rs       = (33'(r_size) + 33'd7) & ~33'd7;
    assign sp_len   = (r_phase == PH_ALLOC) ? rd.len : grow_len[LEN_W-1:0];
    assign sp_at    = (r_phase == PH_ALLOC) ? r_at : fa;
    assign do_split = 34'(sp_len) >= (34'(rs) + 34'(8 + HEADER_BYTES));
    assign rel_len  = 19'(r_prv_len) + merged + HDR19;
    assign rel_len18 = (r_prv_ok && !r_prv_used) ? rel_len[LEN_W-1:0] : merged[LEN_W-1:0];
    assign keep     = (r_size < SIZE_W'(fl)) ? r_size[LEN_W-1:0] : fl;
    assign keep_r   = (19'(keep) + 19'd7) & ~19'd7;

    logic resolve, miss;
    assign resolve = (r_phase == PH_NEXT) ||
                     (r_phase == PH_FIND && is_hit && rd.used && is_last);
    assign miss    = (is_hit && !rd.used) || (!is_hit && (is_past || is_last));

    logic accept, out_free;
    assign accept   = i_req.valid && i_req.ready;
    assign out_free = !r_o_valid || o_res.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_FMT: n_state = i_cfg_we ? S_FMT : S_IDLE;
            S_IDLE: begin
                if (i_cfg_we) begin
                    n_state = S_FMT;
                end else if (accept) begin
                    if (i_req.command == CMD_NONE || heap_empty) n_state = S_DONE;
                    else n_state = S_RD;
                end
            end
            S_RD: n_state = S_EVAL;
            S_EVAL: begin
                case (r_phase)
                    PH_ALLOC: begin
                        if (cur_fit) n_state = S_WR1;
                        else if (is_last) n_state = S_DONE;
                        else n_state = S_RD;
                    end
                    PH_FIND, PH_NEXT: begin
                        if (resolve) begin
                            if (r_rel || grow_ok) n_state = S_WR1;
                            else n_state = S_RD;
                        end else if (r_phase == PH_FIND && miss && r_rel) begin
                            n_state = S_DONE;
                        end else begin
                            n_state = S_RD;
                        end
                    end
                    default: n_state = S_DONE;
                endcase
            end
            S_WR1: n_state = r_two ? S_WR2 : (r_after ? S_RD : S_DONE);
            S_WR2: n_state = r_after ? S_RD : S_DONE;
            S_DONE: if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        i_req.ready          = (r_state == S_IDLE) && !i_cfg_we;
        o_res.valid          = r_o_valid;
        o_res.result_address = r_o_res;
        o_res.copy_source    = r_o_src;
        o_res.copy_bytes     = r_o_bytes;
        o_res.out_of_memory  = r_o_oom;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_FMT;
            r_pages   <= PAGE_W'(MAX_PAGES);
            r_o_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_IDLE || r_state == S_FMT) && i_cfg_we) r_pages <= i_cfg_wdata;
            if (r_state == S_DONE && out_free) r_o_valid <= 1'b1;
            else if (o_res.ready) r_o_valid <= 1'b0;
        end
    end

    // walk and result datapath
    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            r_o_res   <= r_res;
            r_o_src   <= r_src;
            r_o_bytes <= r_bytes;
            r_o_oom   <= r_oom;
        end
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    r_size   <= i_req.request_bytes;
                    r_m      <= i_req.block_address;
                    r_at     <= ADDR_W'(HEAP_BASE);
                    r_prv_ok <= 1'b0;
                    r_moving <= 1'b0;
                    r_rel    <= (i_req.command == CMD_RELEASE);
                    r_phase  <= (i_req.command == CMD_ALLOC) ? PH_ALLOC : PH_FIND;
                    r_res    <= '0;
                    r_src    <= '0;
                    r_bytes  <= '0;
                    r_oom    <= heap_empty && (i_req.command == CMD_ALLOC ||
                                               i_req.command == CMD_RESIZE);
                end
            end
            S_EVAL: begin
                case (r_phase)
                    PH_ALLOC: begin
                        if (cur_fit) begin
                            r_res <= at_data[ADDR_W-1:0];
                            if (r_moving) begin
                                r_src   <= r_m;
                                r_bytes <= r_keep;
                            end
                            r_wa1    <= sp_at;
                            r_wd1    <= '{used: 1'b1,
                                          len: do_split ? rs[LEN_W-1:0] : sp_len};
                            r_wa2    <= ADDR_W'(19'(sp_at) + HDR19 + rs[18:0]);
                            r_wd2    <= '{used: 1'b0,
                                          len: LEN_W'(sp_len - rs[LEN_W-1:0] - LEN_W'(HEADER_BYTES))};
                            r_two    <= do_split;
                            r_after  <= r_moving;
                            // set up the walk that releases the old block
                            r_at     <= ADDR_W'(HEAP_BASE);
                            r_prv_ok <= 1'b0;
                            r_phase  <= PH_FIND;
                            r_rel    <= 1'b1;
                        end else if (is_last) begin
                            r_oom <= 1'b1;
                        end else begin
                            r_at <= nxt_at[ADDR_W-1:0];
                        end
                    end
                    PH_FIND, PH_NEXT: begin
                        if (r_phase == PH_FIND && is_hit && rd.used) begin
                            r_cur_len <= rd.len;
                            r_fnd_at  <= r_at;
                            if (!is_last) begin
                                r_at    <= nxt_at[ADDR_W-1:0];
                                r_phase <= PH_NEXT;
                            end
                        end
                        if (resolve) begin
                            if (r_rel) begin
                                r_wa1   <= (r_prv_ok && !r_prv_used) ? r_prv_at : fa;
                                r_wd1   <= '{used: 1'b0, len: rel_len18};
                                r_two   <= 1'b0;
                                r_after <= 1'b0;
                            end else if (grow_ok) begin
                                r_res   <= r_m;
                                r_wa1   <= sp_at;
                                r_wd1   <= '{used: 1'b1,
                                             len: do_split ? rs[LEN_W-1:0] : sp_len};
                                r_wa2   <= ADDR_W'(19'(sp_at) + HDR19 + rs[18:0]);
                                r_wd2   <= '{used: 1'b0,
                                             len: LEN_W'(sp_len - rs[LEN_W-1:0] - LEN_W'(HEADER_BYTES))};
                                r_two   <= do_split;
                                r_after <= 1'b0;
                            end else begin
                                // move: allocate elsewhere first
                                r_keep   <= keep_r[LEN_W-1:0];
                                r_moving <= 1'b1;
                                r_phase  <= PH_ALLOC;
                                r_at     <= ADDR_W'(HEAP_BASE);
                            end
                        end else if (r_phase == PH_FIND && miss) begin
                            if (!r_rel) begin
                                // resize of an unknown block acts as allocate
                                r_phase <= PH_ALLOC;
                                r_at    <= ADDR_W'(HEAP_BASE);
                            end
                        end else if (r_phase == PH_FIND && !(is_hit && rd.used)) begin
                            r_prv_ok   <= 1'b1;
                            r_prv_at   <= r_at;
                            r_prv_len  <= rd.len;
                            r_prv_used <= rd.used;
                            r_at       <= nxt_at[ADDR_W-1:0];
                        end
                    end
                    default: r_phase <= PH_ALLOC;
                endcase
            end
            default: ;
        endcase
    end

    // checks
    `FFHA_ASSERT_IMPL(a_we_states, mem_we,
        (r_state == S_FMT || r_state == S_WR1 || r_state == S_WR2),
        "header write outside a write state")
    `FFHA_ASSERT_IMPL(a_walk_aligned, r_state == S_RD,
        (r_at[2:0] == 3'd0 && 19'(r_at) >= 19'(HEAP_BASE) && 19'(r_at) < heap_end),
        "walk pointer off the heap")
    `FFHA_ASSERT_IMPL(a_oom_zero, r_o_valid && r_o_oom,
        (r_o_res == '0 && r_o_src == '0 && r_o_bytes == '0),
        "out of memory with nonzero fields")
    `FFHA_ASSERT_NEXT(a_none_done, accept && i_req.command == CMD_NONE,
        (r_state == S_DONE && r_oom == 1'b0),
        "unused command not finished at once")
endmodule
`default_nettype wire
